/* design/lict_pkg.sv */
package lict_pkg;

    localparam int ID_W  = 64;
    localparam int CNT_W = 64;
    localparam int LIM_W = 5;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;
        logic shift;
        logic resident;
    } cell_ctrl_t;

endpackage

/* design/lict_if.sv */
interface lict_cfg_if import lict_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink (input valid, input capacity_limit, output ready);
endinterface

interface lict_in_if import lict_pkg::*;;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] vertex_id;

    modport source (output valid, output vertex_id, input ready);
    modport sink (input valid, input vertex_id, output ready);
endinterface

interface lict_out_if import lict_pkg::*;;
    logic             valid;
    logic             ready;
    logic             hit;
    logic             evicted_valid;
    logic [ID_W-1:0]  evicted_id;
    logic [CNT_W-1:0] request_total;
    logic [CNT_W-1:0] hit_total;

    modport source (
        output valid, output hit, output evicted_valid, output evicted_id,
        output request_total, output hit_total, input ready
    );
    modport sink (
        input valid, input hit, input evicted_valid, input evicted_id,
        input request_total, input hit_total, output ready
    );
endinterface

/* design/lru_id_cache_tracker_core.sv */
// channel  | dir | transaction payload
// ---------+-----+-----------------------------------------------------------
// cfg      | in  | capacity_limit (5 bits)
// lookup   | in  | vertex_id (64 bits)
// result   | out | hit, evicted_valid, evicted_id, request_total, hit_total
//
// on acceptance of a lookup every cell compares its identifier; in the update
// state the chain of cells shifts and the result register loads.
// the result register lets a lookup be accepted while a result waits;
// the update cycle then stalls until the result is taken.
// reset empties the store, clears both counters and sets the limit to 16.
module lru_id_cache_tracker_core import lict_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    lict_cfg_if.sink    cfg,
    lict_in_if.sink     lookup,
    lict_out_if.source  result
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > LIM_W) ? CW : LIM_W;

    state_t           state_reg, state_next;
    logic [LIM_W-1:0] limit_reg, limit_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0] req_count_reg, req_count_next;
    logic [CNT_W-1:0] hit_count_reg, hit_count_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic [ID_W-1:0]  lru_reg, lru_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_hit_reg, out_hit_next;
    logic             out_ev_valid_reg, out_ev_valid_next;
    logic [ID_W-1:0]  out_ev_id_reg, out_ev_id_next;

    logic [ID_W-1:0]  cell_id [ENTRIES];
    logic [ENTRIES-1:0] match;
    cell_ctrl_t       ctrl [ENTRIES];

    logic             accept;
    logic             fire;
    logic             hit;
    logic [IW-1:0]    hit_idx;
    logic [CW-1:0]    occ_minus1;
    logic [LW-1:0]    limit_ext;
    logic [LW-1:0]    eff_limit;
    logic [LW-1:0]    occ_inc;
    logic             evict;

    assign accept = lookup.valid && lookup.ready;
    assign fire   = (state_reg == ST_UPDATE) && (!out_valid_reg || result.ready);

    assign lookup.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    // row of cells, most recent first
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        logic [ID_W-1:0] prev;

        if (k == 0)
        begin : g_head
            assign prev = key_reg;
        end
        else
        begin : g_body
            assign prev = cell_id[k-1];
        end

        assign ctrl[k].capture  = accept;
        assign ctrl[k].resident = (CW'(k) < occ_reg);
        assign ctrl[k].shift    = fire && (!hit || (IW'(k) <= hit_idx));

        lict_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[k]),
            .key     (lookup.vertex_id),
            .prev_id (prev),
            .id      (cell_id[k]),
            .match   (match[k])
        );
    end

    assign hit = |match;

    always_comb
    begin
        hit_idx = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (match[k])
            begin
                hit_idx = hit_idx | IW'(k);
            end
        end
    end

    assign occ_minus1 = occ_reg - CW'(1);

    // a limit of zero acts as one, above the store size as the store size
    assign limit_ext = LW'(limit_reg);
    assign eff_limit = (limit_reg == '0) ? LW'(1) :
                       (limit_ext > LW'(ENTRIES)) ? LW'(ENTRIES) : limit_ext;
    assign occ_inc   = LW'(occ_reg) + LW'(1);
    assign evict     = !hit && (occ_inc >= eff_limit);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        limit_next        = limit_reg;
        occ_next          = occ_reg;
        req_count_next    = req_count_reg;
        hit_count_next    = hit_count_reg;
        key_next          = key_reg;
        lru_next          = lru_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_hit_next      = out_hit_reg;
        out_ev_valid_next = out_ev_valid_reg;
        out_ev_id_next    = out_ev_id_reg;

        if (cfg.valid && cfg.ready)
        begin
            limit_next = cfg.capacity_limit;
        end

        if (accept)
        begin
            key_next = lookup.vertex_id;
            // least recent resident entry, candidate for eviction
            lru_next = cell_id[occ_minus1[IW-1:0]];
        end

        if (fire)
        begin
            req_count_next    = req_count_reg + CNT_W'(1);
            out_valid_next    = 1'b1;
            out_hit_next      = hit;
            out_ev_valid_next = evict;
            out_ev_id_next    = '0;
            if (hit)
            begin
                hit_count_next = hit_count_reg + CNT_W'(1);
            end
            else if (evict)
            begin
                // empty store: the new identifier itself is evicted
                out_ev_id_next = (occ_reg == '0) ? key_reg : lru_reg;
            end
            else
            begin
                occ_next = occ_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            occ_reg       <= '0;
            req_count_reg <= '0;
            hit_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            occ_reg       <= occ_next;
            req_count_reg <= req_count_next;
            hit_count_reg <= hit_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg          <= key_next;
        lru_reg          <= lru_next;
        out_hit_reg      <= out_hit_next;
        out_ev_valid_reg <= out_ev_valid_next;
        out_ev_id_reg    <= out_ev_id_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.hit           = out_hit_reg;
    assign result.evicted_valid = out_ev_valid_reg;
    assign result.evicted_id    = out_ev_id_reg;
    assign result.request_total = req_count_reg;
    assign result.hit_total     = hit_count_reg;

endmodule

/* design/lict_cell.sv */
module lict_cell import lict_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cell_ctrl_t      ctrl,
    input  logic [ID_W-1:0] key,
    input  logic [ID_W-1:0] prev_id,
    output logic [ID_W-1:0] id,
    output logic            match
);

    logic [ID_W-1:0] id_reg;
    logic            match_reg;
    logic            match_next;

    // identifier moves one place toward least recent when shifted
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            id_reg <= prev_id;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = ctrl.resident && (id_reg == key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign id    = id_reg;
    assign match = match_reg;

endmodule

/* verif/lru_id_cache_tracker_core_tb.sv */
`timescale 1ns / 1ps

module lru_id_cache_tracker_core_tb;
    import lict_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic             hit;
        logic             evicted_valid;
        logic [ID_W-1:0]  evicted_id;
        logic [CNT_W-1:0] request_total;
        logic [CNT_W-1:0] hit_total;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    lict_cfg_if cfg_bus();
    lict_in_if  lookup_bus();
    lict_out_if result_bus();

    lru_id_cache_tracker_core #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .lookup (lookup_bus),
        .result (result_bus)
    );

    // predictor state: resident ids, most recent first
    logic [ID_W-1:0]  lru_order[$];
    logic [CNT_W-1:0] request_count;
    logic [CNT_W-1:0] hit_count;
    logic [LIM_W-1:0] limit_reg;

    lookup_result_t   expected_results[$];
    logic [ID_W-1:0]  pending_ids[$];
    logic [ID_W-1:0]  id_pool[POOL_SIZE];
    logic [ID_W-1:0]  last_id;

    int  sent_count;
    int  accepted_count;
    int  mismatch_count;
    bit  idle_mode;
    bit  in_taken;
    bit  cfg_taken;
    int  gap_left;
    int  stall_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic lookup_result_t predict_lookup(input logic [ID_W-1:0] id);
        lookup_result_t r;
        int pos;
        int eff;
        r = '0;
        pos = -1;
        foreach (lru_order[i])
        begin
            if (pos < 0 && lru_order[i] == id)
                pos = i;
        end
        if (limit_reg == '0)
            eff = 1;
        else if (int'(limit_reg) > ENTRIES)
            eff = ENTRIES;
        else
            eff = int'(limit_reg);
        request_count = request_count + 1'b1;
        if (pos >= 0)
        begin
            hit_count = hit_count + 1'b1;
            r.hit = 1'b1;
            lru_order.delete(pos);
            lru_order.insert(0, id);
        end
        else
        begin
            if (lru_order.size() < ENTRIES)
                lru_order.insert(0, id);
            // evict least recent once occupancy reaches the limit
            if (lru_order.size() >= eff)
            begin
                r.evicted_valid = 1'b1;
                r.evicted_id = lru_order[lru_order.size() - 1];
                lru_order.delete(lru_order.size() - 1);
            end
        end
        r.request_total = request_count;
        r.hit_total = hit_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // acceptance, prediction and checking all happen at the rising edge
    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n)
        begin
            in_taken  <= lookup_bus.valid && lookup_bus.ready;
            cfg_taken <= cfg_bus.valid && cfg_bus.ready;
            if (cfg_bus.valid && cfg_bus.ready)
                limit_reg = cfg_bus.capacity_limit;
            if (lookup_bus.valid && lookup_bus.ready)
            begin
                expected_results.push_back(predict_lookup(lookup_bus.vertex_id));
                accepted_count++;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, result_bus.request_total);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("hit", 64'(exp_r.hit), 64'(result_bus.hit));
                    check_field("evicted_valid", 64'(exp_r.evicted_valid),
                                64'(result_bus.evicted_valid));
                    check_field("evicted_id", exp_r.evicted_id, result_bus.evicted_id);
                    check_field("request_total", exp_r.request_total,
                                result_bus.request_total);
                    check_field("hit_total", exp_r.hit_total, result_bus.hit_total);
                end
            end
        end
    end

    // lookup driver
    always @(negedge clk)
    begin
        if (lookup_bus.valid && !in_taken)
        begin
            // hold the transaction until it is taken
        end
        else if (gap_left > 0)
        begin
            lookup_bus.valid <= 1'b0;
            gap_left--;
        end
        else if (pending_ids.size() > 0)
        begin
            if (idle_mode && $urandom_range(0, 5) == 0)
            begin
                lookup_bus.valid <= 1'b0;
                gap_left = $urandom_range(0, 15);
            end
            else
            begin
                lookup_bus.valid <= 1'b1;
                lookup_bus.vertex_id <= pending_ids.pop_front();
            end
        end
        else
        begin
            lookup_bus.valid <= 1'b0;
        end
    end

    // result receiver with stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_bus.ready <= 1'b0;
            stall_left--;
        end
        else if (idle_mode && $urandom_range(0, 5) == 0)
        begin
            result_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end
        else
        begin
            result_bus.ready <= 1'b1;
        end
    end

    function automatic logic [ID_W-1:0] rand_id();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ID_W-1:0] next_id();
        int pick;
        logic [ID_W-1:0] id;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick == 7)
            id = rand_id();
        else if (pick == 8)
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (64'd1 << $urandom_range(0, 63));
        else
            id = last_id;
        last_id = id;
        return id;
    endfunction

    task automatic push_lookup(input logic [ID_W-1:0] id);
        pending_ids.push_back(id);
        sent_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != sent_count || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limit(input logic [LIM_W-1:0] lim);
        wait_idle();
        cfg_bus.capacity_limit <= lim;
        cfg_bus.valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [LIM_W-1:0] lim, input int n, input bit idling);
        set_limit(lim);
        idle_mode = idling;
        repeat (6) id_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_id();
        repeat (n) push_lookup(next_id());
    endtask

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.capacity_limit = '0;
        lookup_bus.valid = 1'b0;
        lookup_bus.vertex_id = '0;
        result_bus.ready = 1'b0;
        lru_order.delete();
        request_count = '0;
        hit_count = '0;
        limit_reg = LIMIT_RESET;
        sent_count = 0;
        accepted_count = 0;
        mismatch_count = 0;
        idle_mode = 1'b1;
        in_taken = 1'b0;
        cfg_taken = 1'b0;
        gap_left = 0;
        stall_left = 0;
        last_id = '0;
        foreach (id_pool[i])
            id_pool[i] = rand_id();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // limit of one on an empty store evicts each id just installed
        set_limit(5'd1);
        push_lookup(64'h0);
        push_lookup(64'hFFFF_FFFF_FFFF_FFFF);
        push_lookup(64'h0);
        // limit of zero acts as one
        set_limit(5'd0);
        push_lookup(64'h5555_5555_5555_5555);
        set_limit(5'd2);
        push_lookup(64'hAAAA_AAAA_AAAA_AAAA);
        push_lookup(64'hAAAA_AAAA_AAAA_AAAA);
        push_lookup(64'h0);
        push_lookup(64'hFFFF_FFFF_FFFF_FFFF);
        push_lookup(64'hFFFF_FFFF_FFFF_FFFF);
        // limit above the entry count saturates
        set_limit(5'd31);
        push_lookup(64'h1);
        push_lookup(64'h8000_0000_0000_0000);
        push_lookup(64'h7FFF_FFFF_FFFF_FFFF);
        push_lookup(64'hFFFF_FFFF_FFFF_FFFF);
        push_lookup(64'h1);
        push_lookup(64'hFFFF_FFFF_FFFF_FFFE);

        random_phase(5'd8, 80, 1'b1);
        random_phase(5'd12, 80, 1'b1);
        random_phase(5'd16, 90, 1'b0);
        random_phase(5'd31, 80, 1'b1);
        random_phase(5'd20, 70, 1'b1);
        // lowered below occupancy: one eviction per miss
        random_phase(5'd5, 70, 1'b1);
        random_phase(5'd1, 60, 1'b1);
        random_phase(5'd16, 100, 1'b0);

        wait_idle();
        repeat (16) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
design/lict_pkg.sv
design/lict_if.sv
design/lict_cell.sv
design/lru_id_cache_tracker_core.sv
verif/lru_id_cache_tracker_core_tb.sv
